>>> design/selective_repeat_receiver_defines.svh
// Assertion macros shared by the receiver RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH

// Condition that holds at every clock edge outside reset.
`define SRR_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/srr_pkg.sv
// Package for the selective-repeat receiver: sizes, codes, slot types, byte sum.
// No dependencies.
package srr_pkg;

  localparam int SLOT_COUNT = 1024;              // power of two
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int MAX_WINDOW = 32;
  localparam int WIN_W      = 6;
  localparam int SEQ_W      = 31;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  localparam logic [SEQ_W-1:0] BASE_RESET      = SEQ_W'(1);
  localparam logic [WIN_W-1:0] WINDOW_RESET    = WIN_W'(8);
  localparam logic [31:0]      ACK_PAYLOAD_SUM = 32'd654;

  // Accumulator steps: ack number, then five words of four payload bytes.
  localparam int               SUM_STEPS = 6;
  localparam logic [2:0]       STEP_LAST = 3'(SUM_STEPS - 1);

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_WAIT,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic             occ;
    logic [SEQ_W-1:0] seq;
    logic [63:0]      lo;
    logic [63:0]      mid;
    logic [31:0]      hi;
  } slot_entry_t;

  typedef struct packed {
    logic                 we;
    logic [SLOT_BITS-1:0] addr;
    slot_entry_t          data;
  } slot_wr_t;

  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] number;
    logic [31:0]      cks;
    logic [63:0]      lo;
    logic [63:0]      mid;
    logic [31:0]      hi;
  } result_t;

  // Sum of four bytes taken as signed values, 32-bit wrap.
  function automatic logic [31:0] byte_sum4(input logic [31:0] w);
    logic [31:0] s;
    s = '0;
    for (int k = 0; k < 4; k++) begin
      s = s + {{24{w[8*k+7]}}, w[8*k +: 8]};
    end
    return s;
  endfunction

endpackage

>>> design/srr_slot_store.sv
// Slot store of the receiver: one write port, one registered read port.
// Depends on srr_pkg for the slot entry and write request types.
module srr_slot_store
  import srr_pkg::*;
(
  input  logic                 clk,
  input  slot_wr_t             wr,
  input  logic [SLOT_BITS-1:0] rd_addr,
  output slot_entry_t          rd_data
);

  slot_entry_t mem [SLOT_COUNT];

  // Write at one address, read another, read data registered
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/selective_repeat_receiver.sv
// Top level of the selective-repeat receiver: checksum, window, slot store, delivery.
// Depends on srr_pkg, srr_slot_store and selective_repeat_receiver_defines.svh.
//
//   channel   handshake              beat
//   input     start & !busy          seq_num, ack_num, pkt_checksum, payload_*
//   config    cfg_we                 cfg_data (window width)
//   result    done, one cycle each   kind, number, ack_checksum, out_payload_*, last
//
// After reset a clearing pass walks the slot store, one slot a cycle, with busy
// high; config writes are taken meanwhile.
// Accumulate and check keep busy high: six add steps on the one shared adder, then the check.
// A dropped packet frees the input after the check; a duplicate's acknowledgement is
// registered in the check state, a new packet's last result after its deliveries (at most 32).
// Results leave one per cycle in a contiguous burst; the receiver cannot stall.
`include "selective_repeat_receiver_defines.svh"

module selective_repeat_receiver
  import srr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cfg_we,
  input  logic [WIN_W-1:0]        cfg_data,
  input  logic [SEQ_W-1:0]        seq_num,
  input  logic [SEQ_W-1:0]        ack_num,
  input  logic signed [31:0]      pkt_checksum,
  input  logic [63:0]             payload_low,
  input  logic [63:0]             payload_middle,
  input  logic [31:0]             payload_high,
  output logic                    done,
  output logic                    kind,
  output logic [SEQ_W-1:0]        number,
  output logic signed [31:0]      ack_checksum,
  output logic [63:0]             out_payload_low,
  output logic [63:0]             out_payload_middle,
  output logic [31:0]             out_payload_high,
  output logic                    last
);

  state_t               state, state_next;
  logic [WIN_W-1:0]     window_size;
  logic [SEQ_W-1:0]     base;
  logic [SLOT_BITS-1:0] clr_addr;
  logic [2:0]           step;
  logic [CNT_W-1:0]     cnt;
  logic [31:0]          acc;
  logic [SEQ_W-1:0]     seq_r, ack_r;
  logic [31:0]          cks_r;
  logic [63:0]          lo_r, mid_r;
  logic [31:0]          hi_r;
  result_t              held;

  slot_wr_t             wr;
  logic [SLOT_BITS-1:0] rd_addr;
  slot_entry_t          rd_data;

  logic [WIN_W-1:0]     win;
  logic [31:0]          operand;
  logic [SEQ_W-1:0]     offset;
  logic [31:0]          ack_tmp;
  logic [31:0]          ack_cks;
  logic                 cks_ok, is_dup, in_win, deliver;

  srr_slot_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Saturate the window and derive the packet tests
  always_comb begin
    win     = (window_size > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_size;
    cks_ok  = ({acc[30:0], 1'b0} == cks_r);
    is_dup  = rd_data.occ && (rd_data.seq == seq_r);
    offset  = seq_r - base;
    in_win  = (offset < SEQ_W'(win));
    ack_tmp = {seq_r, 1'b0} + ACK_PAYLOAD_SUM;
    ack_cks = {ack_tmp[30:0], 1'b0};
    deliver = rd_data.occ && (rd_data.seq == base) && (cnt < CNT_W'(win));
  end

  // Select the accumulator operand for this step
  always_comb begin
    case (step)
      3'd0:    operand = {1'b0, ack_r};
      3'd1:    operand = byte_sum4(lo_r[31:0]);
      3'd2:    operand = byte_sum4(lo_r[63:32]);
      3'd3:    operand = byte_sum4(mid_r[31:0]);
      3'd4:    operand = byte_sum4(mid_r[63:32]);
      default: operand = byte_sum4(hi_r);
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, store addressing
  always_comb begin
    state_next = state;
    wr         = '0;
    rd_addr    = seq_r[SLOT_BITS-1:0];
    busy       = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        wr.we   = 1'b1;
        wr.addr = clr_addr;
        if (clr_addr == SLOT_BITS'(SLOT_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr = seq_num[SLOT_BITS-1:0];
        if (start) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (step == STEP_LAST) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cks_ok && !is_dup && in_win) begin
          wr.we       = 1'b1;
          wr.addr     = seq_r[SLOT_BITS-1:0];
          wr.data.occ = 1'b1;
          wr.data.seq = seq_r;
          wr.data.lo  = lo_r;
          wr.data.mid = mid_r;
          wr.data.hi  = hi_r;
          state_next  = ST_WAIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WAIT: begin
        rd_addr = base[SLOT_BITS-1:0];
        state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (deliver) begin
          rd_addr = base[SLOT_BITS-1:0] + SLOT_BITS'(1);
        end else begin
          rd_addr    = base[SLOT_BITS-1:0];
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers: clear sweep, window, base, counters, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      window_size <= WINDOW_RESET;
      base        <= BASE_RESET;
      step        <= '0;
      cnt         <= '0;
      done        <= 1'b0;
      last        <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_data;
      end
      done <= 1'b0;
      last <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + SLOT_BITS'(1);
        end
        ST_IDLE: begin
          step <= '0;
        end
        ST_SUM: begin
          step <= step + 3'd1;
        end
        ST_CHECK: begin
          cnt <= '0;
          if (cks_ok && is_dup) begin
            done <= 1'b1;
            last <= 1'b1;
          end
        end
        ST_DELIVER: begin
          done <= 1'b1;
          last <= !deliver;
          if (deliver) begin
            base <= base + SEQ_W'(1);
            cnt  <= cnt + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath: latch the packet, run the shared adder, stage and emit results
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          seq_r <= seq_num;
          ack_r <= ack_num;
          cks_r <= pkt_checksum;
          lo_r  <= payload_low;
          mid_r <= payload_middle;
          hi_r  <= payload_high;
          acc   <= {1'b0, seq_num};
        end
      end
      ST_SUM: begin
        acc <= acc + operand;
      end
      ST_CHECK: begin
        held.kind   <= KIND_ACK;
        held.number <= seq_r;
        held.cks    <= ack_cks;
        held.lo     <= '0;
        held.mid    <= '0;
        held.hi     <= '0;
        if (cks_ok && is_dup) begin
          kind               <= KIND_ACK;
          number             <= seq_r;
          ack_checksum       <= ack_cks;
          out_payload_low    <= '0;
          out_payload_middle <= '0;
          out_payload_high   <= '0;
        end
      end
      ST_DELIVER: begin
        kind               <= held.kind;
        number             <= held.number;
        ack_checksum       <= held.cks;
        out_payload_low    <= held.lo;
        out_payload_middle <= held.mid;
        out_payload_high   <= held.hi;
        if (deliver) begin
          held.kind   <= KIND_DELIVER;
          held.number <= base;
          held.cks    <= '0;
          held.lo     <= rd_data.lo;
          held.mid    <= rd_data.mid;
          held.hi     <= rd_data.hi;
        end
      end
      default: begin
      end
    endcase
  end

  // A non-final result is always followed by another in the next cycle
  `SRR_ASSERT_NEXT(a_burst_contiguous, done && !last, done, "result burst broken")
  // An accepted packet makes the block busy
  `SRR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "not busy after accept")
  // No result comes out during the clearing pass
  `SRR_ASSERT(a_no_result_in_clear, !(state == ST_CLEAR && done), "result during clear")
  // Deliveries per packet stay within the largest window
  `SRR_ASSERT(a_cnt_bound, cnt <= CNT_W'(MAX_WINDOW), "delivery count overrun")

endmodule

>>> tb/sv/selective_repeat_receiver_tb.sv
// Self-checking testbench for selective_repeat_receiver: directed window cases, then random traffic.
// Depends on srr_pkg and the selective_repeat_receiver RTL; results are predicted in place.
module selective_repeat_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srr_pkg::*;

  localparam int CLOCK_HALF     = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 45;
  localparam int ITEM_GOAL      = 380;
  localparam int PAYLOAD_BYTES  = 20;

  localparam logic [WIN_W-1:0] WIN_CLOSED = WIN_W'(0);
  localparam logic [WIN_W-1:0] WIN_SINGLE = WIN_W'(1);
  localparam logic [WIN_W-1:0] WIN_PAIR   = WIN_W'(2);
  localparam logic [WIN_W-1:0] WIN_FULL   = WIN_W'(MAX_WINDOW);
  localparam logic [WIN_W-1:0] WIN_WIDEST = '1;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] ack;
    logic [31:0]      cks;
    logic [159:0]     data;
  } pkt_t;

  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] number;
    logic [31:0]      cks;
    logic [63:0]      lo;
    logic [63:0]      mid;
    logic [31:0]      hi;
    logic             last;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               cfg_we = 1'b0;
  logic [WIN_W-1:0]   cfg_data = '0;
  logic [SEQ_W-1:0]   seq_num = '0;
  logic [SEQ_W-1:0]   ack_num = '0;
  logic signed [31:0] pkt_checksum = '0;
  logic [63:0]        payload_low = '0;
  logic [63:0]        payload_middle = '0;
  logic [31:0]        payload_high = '0;
  logic               busy;
  logic               done;
  logic               kind;
  logic [SEQ_W-1:0]   number;
  logic signed [31:0] ack_checksum;
  logic [63:0]        out_payload_low;
  logic [63:0]        out_payload_middle;
  logic [31:0]        out_payload_high;
  logic               last;

  // Receiver image: window register, delivery base and slot store
  logic [WIN_W-1:0]   win_reg;
  logic [SEQ_W-1:0]   next_deliver;
  logic               hold_valid [SLOT_COUNT];
  logic [SEQ_W-1:0]   hold_seq [SLOT_COUNT];
  logic [159:0]       hold_data [SLOT_COUNT];

  reply_t owed_replies[$];
  int     sent_pkts = 0;
  int     faults = 0;
  int     burst_left = 0;
  int     idle_cycles = 0;

  selective_repeat_receiver dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .seq_num            (seq_num),
    .ack_num            (ack_num),
    .pkt_checksum       (pkt_checksum),
    .payload_low        (payload_low),
    .payload_middle     (payload_middle),
    .payload_high       (payload_high),
    .done               (done),
    .kind               (kind),
    .number             (number),
    .ack_checksum       (ack_checksum),
    .out_payload_low    (out_payload_low),
    .out_payload_middle (out_payload_middle),
    .out_payload_high   (out_payload_high),
    .last               (last)
  );

  always begin
    #CLOCK_HALF clk = 1'b1;
    #CLOCK_HALF clk = 1'b0;
  end

  // Twice the sum of seq, ack and the signed payload bytes, 32-bit wrap
  function automatic logic [31:0] packet_checksum(input pkt_t p);
    int  total;
    int  sb;
    byte b;
    total = int'(p.seq) + int'(p.ack);
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      b = p.data[8*k +: 8];
      sb = b;
      total = total + sb;
    end
    return total * 2;
  endfunction

  function automatic pkt_t sealed_packet(input logic [SEQ_W-1:0] seq,
                                         input logic [SEQ_W-1:0] ack,
                                         input logic [159:0] data);
    pkt_t p;
    p.seq  = seq;
    p.ack  = ack;
    p.data = data;
    p.cks  = packet_checksum(p);
    return p;
  endfunction

  function automatic string show_reply(input reply_t r);
    return $sformatf("kind=%0d number=%h cks=%h payload=%h_%h_%h last=%0d",
                     r.kind, r.number, r.cks, r.hi, r.mid, r.lo, r.last);
  endfunction

  // Work out the acknowledgement and the in-order deliveries one packet causes
  function automatic void ack_and_deliver(input pkt_t p);
    logic [31:0]      ack_cks;
    logic [SEQ_W-1:0] offset;
    int unsigned      span;
    int unsigned      slot;
    int unsigned      s;
    reply_t           tail;
    if (packet_checksum(p) != p.cks) return;
    ack_cks = (32'(p.seq) * 2 + ACK_PAYLOAD_SUM) * 2;
    tail = '{KIND_ACK, p.seq, ack_cks, 64'd0, 64'd0, 32'd0, 1'b0};
    slot = p.seq % SLOT_COUNT;
    // re-acknowledge a packet still held in its slot
    if (hold_valid[slot] && hold_seq[slot] == p.seq) begin
      tail.last = 1'b1;
      owed_replies.push_back(tail);
      return;
    end
    span = (win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg;
    offset = p.seq - next_deliver;
    if (offset >= span) return;
    hold_valid[slot] = 1'b1;
    hold_seq[slot]   = p.seq;
    hold_data[slot]  = p.data;
    // drain the in-order run, one window at most
    for (int i = 0; i < span; i++) begin
      s = next_deliver % SLOT_COUNT;
      if (!hold_valid[s] || hold_seq[s] != next_deliver) break;
      owed_replies.push_back(tail);
      tail = '{KIND_DELIVER, next_deliver, 32'd0, hold_data[s][63:0],
               hold_data[s][127:64], hold_data[s][159:128], 1'b0};
      next_deliver = next_deliver + 1'b1;
    end
    tail.last = 1'b1;
    owed_replies.push_back(tail);
  endfunction

  // Offer one packet, with bursts and random gaps between bursts
  task automatic send_packet(input pkt_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 45);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    start          <= 1'b1;
    seq_num        <= p.seq;
    ack_num        <= p.ack;
    pkt_checksum   <= p.cks;
    payload_low    <= p.data[63:0];
    payload_middle <= p.data[127:64];
    payload_high   <= p.data[159:128];
    do @(posedge clk); while (busy !== 1'b0);
    sent_pkts++;
    ack_and_deliver(p);
  endtask

  // Hold off the sender until every owed result is back and the block is quiet
  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] w);
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we   <= 1'b0;
    win_reg = w;
  endtask

  // In-order, out-of-order, duplicate, corrupt and out-of-window packets at reset width
  task automatic test_reset_window();
    pkt_t p;
    send_packet(sealed_packet(SEQ_W'(1), SEQ_W'(0), '0));
    send_packet(sealed_packet(SEQ_W'(3), '1, '1));
    send_packet(sealed_packet(SEQ_W'(2), SEQ_W'(5), {PAYLOAD_BYTES{8'h80}}));
    send_packet(sealed_packet(SEQ_W'(1), SEQ_W'(9), {PAYLOAD_BYTES{8'h7f}}));
    p = sealed_packet(SEQ_W'(4), SEQ_W'(0), '0);
    p.cks = p.cks ^ 32'h8000_0001;
    send_packet(p);
    send_packet(sealed_packet(SEQ_W'(12), SEQ_W'(1), '0));
    send_packet(sealed_packet(SEQ_W'(11), '1, {$urandom, $urandom, $urandom, $urandom, $urandom}));
    send_packet(sealed_packet('1, '1, '1));
    // same slot as an already held packet, different sequence number
    send_packet(sealed_packet(SEQ_W'(SLOT_COUNT + 1), SEQ_W'(2), '0));
    send_packet(sealed_packet(SEQ_W'(0), SEQ_W'(0), '0));
    settle();
  endtask

  // Closed window: new packets dropped, held ones still re-acknowledged
  task automatic test_window_closed();
    set_window(WIN_CLOSED);
    send_packet(sealed_packet(SEQ_W'(4), SEQ_W'(3), '0));
    send_packet(sealed_packet(SEQ_W'(3), SEQ_W'(3), '1));
    send_packet(sealed_packet(SEQ_W'(11), SEQ_W'(4), '0));
    settle();
  endtask

  // Oversized width saturates to the largest window
  task automatic test_window_saturate();
    set_window(WIN_WIDEST);
    send_packet(sealed_packet(SEQ_W'(4 + MAX_WINDOW - 1), SEQ_W'(7), '1));
    send_packet(sealed_packet(SEQ_W'(4 + MAX_WINDOW), SEQ_W'(7), '1));
    for (int s = 5; s <= 8; s++) begin
      send_packet(sealed_packet(SEQ_W'(s), SEQ_W'($urandom),
                                {$urandom, $urandom, $urandom, $urandom, $urandom}));
    end
    settle();
  endtask

  // Shrunk window caps one delivery run; widen again to release the rest
  task automatic test_window_shrink();
    set_window(WIN_PAIR);
    send_packet(sealed_packet(SEQ_W'(4), SEQ_W'(1), '0));
    settle();
    set_window(WIN_FULL);
    send_packet(sealed_packet(SEQ_W'(9), SEQ_W'(1), '0));
    send_packet(sealed_packet(SEQ_W'(10), SEQ_W'(1), '1));
    settle();
    set_window(WIN_SINGLE);
    send_packet(sealed_packet(SEQ_W'(13), SEQ_W'(2), '0));
    send_packet(sealed_packet(SEQ_W'(12), SEQ_W'(2), '0));
    settle();
  endtask

  // Mostly in-window traffic with random content, some duplicates and noise
  function automatic pkt_t draw_packet();
    pkt_t             p;
    logic [SEQ_W-1:0] seq;
    int unsigned      span;
    int unsigned      roll;
    span = (win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg;
    roll = $urandom_range(0, 99);
    if (roll < 62) begin
      seq = next_deliver + SEQ_W'($urandom_range(0, (span == 0) ? 0 : span - 1));
    end else if (roll < 76) begin
      seq = next_deliver - SEQ_W'($urandom_range(1, 40));
    end else if (roll < 86) begin
      seq = next_deliver + SEQ_W'(span + $urandom_range(0, 8));
    end else begin
      seq = SEQ_W'($urandom);
    end
    p = sealed_packet(seq, SEQ_W'($urandom), {$urandom, $urandom, $urandom, $urandom, $urandom});
    // corrupt about one packet in ten
    case ($urandom_range(0, 19))
      0: p.cks = p.cks ^ (32'd1 << $urandom_range(0, 31));
      1: p.cks = $urandom;
      default: ;
    endcase
    return p;
  endfunction

  task automatic test_random_traffic();
    logic [WIN_W-1:0] w;
    while (sent_pkts < ITEM_GOAL) begin
      case ($urandom_range(0, 11))
        0: w = WIN_CLOSED;
        1: w = WIN_SINGLE;
        2, 3: w = WIN_FULL;
        4: w = WIN_WIDEST;
        5: w = WIN_W'($urandom_range(MAX_WINDOW + 1, 62));
        default: w = WIN_W'($urandom_range(2, MAX_WINDOW - 1));
      endcase
      set_window(w);
      repeat (PHASE_ITEMS) send_packet(draw_packet());
      settle();
    end
  endtask

  // Check each result beat against the oldest owed one
  always @(posedge clk) begin : check_results
    reply_t got;
    reply_t want;
    if (!rst && done === 1'b1) begin
      got = '{kind, number, ack_checksum, out_payload_low, out_payload_middle,
              out_payload_high, last};
      if (owed_replies.size() == 0) begin
        if (faults < MAX_REPORTS) $display("%0t: unexpected result %s", $realtime, show_reply(got));
        faults++;
      end else begin
        want = owed_replies.pop_front();
        if (got.kind !== want.kind || got.number !== want.number || got.cks !== want.cks ||
            got.lo !== want.lo || got.mid !== want.mid || got.hi !== want.hi ||
            got.last !== want.last) begin
          if (faults < MAX_REPORTS) begin
            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                     $realtime, show_reply(want), show_reply(got));
          end
          faults++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("selective_repeat_receiver_tb failed");
      $finish;
    end
  end

  initial begin
    win_reg      = WINDOW_RESET;
    next_deliver = BASE_RESET;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hold_valid[i] = 1'b0;
      hold_seq[i]   = '0;
      hold_data[i]  = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_window();
    test_window_closed();
    test_window_saturate();
    test_window_shrink();
    test_random_traffic();
    if (faults == 0 && owed_replies.size() == 0) begin
      $display("selective_repeat_receiver_tb passed");
    end else begin
      $display("selective_repeat_receiver_tb failed");
    end
    $finish;
  end

endmodule

>>> selective_repeat_receiver.f
+incdir+design
design/srr_pkg.sv
design/srr_slot_store.sv
design/selective_repeat_receiver.sv
tb/sv/selective_repeat_receiver_tb.sv
